FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// each macro expects clk and rst in scope; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every rising edge outside reset
`define ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/core/sslo_pkg.sv
// shared types and constants of the sweeping stripe luma overlay
// no dependencies
`default_nettype none

package sslo_pkg;

  localparam int POS_W  = 14;
  localparam int FRAC_W = 4;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int LUMA_W = 8;
  localparam int PHASE_W = 7;
  localparam int REG_IDX_W = 3;
  localparam int REG_DATA_W = 10;

  localparam logic [LUMA_W-1:0] WHITE_LEVEL = 8'd235;
  localparam logic [FRAC_W:0]   FULL_COVER  = 5'd16;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BOX_LEFT   = 3'd0,
    REG_BOX_RIGHT  = 3'd1,
    REG_BOX_TOP    = 3'd2,
    REG_BOX_BOTTOM = 3'd3,
    REG_ENABLE     = 3'd4,
    REG_PAUSE      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic shown;
    logic busy;
  } sweep_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/sslo_pix_if.sv
// input channel: picture ticks and luma samples
// depends on sslo_pkg
`default_nettype none

interface sslo_pix_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [sslo_pkg::COL_W-1:0]  pixel_x;
  logic [sslo_pkg::ROW_W-1:0]  pixel_y;
  logic [sslo_pkg::LUMA_W-1:0] luma_in;

  modport source (output valid, cmd, pixel_x, pixel_y, luma_in, input ready);
  modport sink (input valid, cmd, pixel_x, pixel_y, luma_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sslo_res_if.sv
// result channel: blended luma
// depends on sslo_pkg
`default_nettype none

interface sslo_res_if;
  logic                       valid;
  logic                       ready;
  logic [sslo_pkg::LUMA_W-1:0] luma_out;

  modport source (output valid, luma_out, input ready);
  modport sink (input valid, luma_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sslo_cfg_if.sv
// configuration write channel: register index and write data
// depends on sslo_pkg
`default_nettype none

interface sslo_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sslo_pkg::REG_IDX_W-1:0]  index;
  logic [sslo_pkg::REG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sslo_sweep.sv
// stripe position generator: triangle phase and per-field positions
// three-stage pipeline (fold, multiply, reciprocal divide); depends on sslo_pkg
`default_nettype none

module sslo_sweep #(
  parameter int STRIPE_WIDTH = 4,
  parameter int SWEEP_LENGTH = 50
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      tick,
  input  wire logic                      enable,
  input  wire logic                      pause,
  input  wire logic [sslo_pkg::COL_W-1:0] box_left,
  input  wire logic [sslo_pkg::COL_W-1:0] box_right,
  output sslo_pkg::pos_t                 positions [2],
  output sslo_pkg::sweep_status_t        status
);
  import sslo_pkg::*;

  localparam int PERIOD = 2 * SWEEP_LENGTH;
  localparam int STEPS  = SWEEP_LENGTH - 1;
  localparam int HALF   = STEPS / 2;
  localparam int F_W    = $clog2(SWEEP_LENGTH);
  localparam int TRAV_W = POS_W;
  localparam int NUM_W  = TRAV_W + F_W + 1;
  localparam int SHIFT  = NUM_W + $clog2(STEPS + 1);
  localparam int RCP_W  = SHIFT + 1;
  localparam logic [RCP_W-1:0] RECIP =
      RCP_W'(((64'd1 << SHIFT) + 64'(STEPS) - 64'd1) / 64'(STEPS));
  localparam int PROD_W = NUM_W + RCP_W;

  logic [PHASE_W-1:0] phase;
  logic               shown;

  // stage 1: travel and folded field index
  logic               s1_valid;
  logic [TRAV_W-1:0]  s1_travel;
  logic [F_W-1:0]     s1_f [2];
  logic [COL_W-1:0]   s1_left;
  // stage 2: rounded numerator
  logic               s2_valid;
  logic [NUM_W-1:0]   s2_num [2];
  logic [COL_W-1:0]   s2_left;
  // stage 3: scaled by reciprocal
  logic               s3_valid;
  logic [PROD_W-1:0]  s3_prod [2];
  logic [COL_W-1:0]   s3_left;

  logic [COL_W+1:0]   span;
  logic [TRAV_W-1:0]  travel;
  logic [PHASE_W-1:0] ph [2];
  logic [PHASE_W-1:0] phase_inc;
  logic [PHASE_W:0]   phase_adv;
  logic [PHASE_W-1:0] phase_next;
  logic [F_W-1:0]     f_fold [2];
  logic               run;

  assign run = tick && enable && !pause;

  always_comb begin
    span = {2'b00, box_right} - (COL_W+2)'(STRIPE_WIDTH) - {2'b00, box_left};
    // narrow box: travel clamps at zero
    travel = span[COL_W+1] ? '0 : {span[COL_W-1:0], {FRAC_W{1'b0}}};
    phase_inc = phase + PHASE_W'(1);
    ph[0] = phase;
    ph[1] = (phase_inc == PHASE_W'(PERIOD)) ? '0 : phase_inc;
    for (int k = 0; k < 2; k++) begin
      f_fold[k] = (ph[k] < PHASE_W'(SWEEP_LENGTH)) ? F_W'(ph[k])
                                                   : F_W'(PHASE_W'(PERIOD - 1) - ph[k]);
    end
    phase_adv = {1'b0, phase} + (PHASE_W+1)'(2);
    phase_next = (phase_adv >= (PHASE_W+1)'(PERIOD))
                   ? PHASE_W'(phase_adv - (PHASE_W+1)'(PERIOD)) : PHASE_W'(phase_adv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      shown    <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= run;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (tick && !run) begin
        shown <= 1'b0;
        phase <= '0;
      end else if (run) begin
        phase <= phase_next;
      end
      if (s3_valid) begin
        shown <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      s1_travel <= travel;
      s1_f[0]   <= f_fold[0];
      s1_f[1]   <= f_fold[1];
      s1_left   <= box_left;
    end
    s2_left <= s1_left;
    s3_left <= s2_left;
    for (int k = 0; k < 2; k++) begin
      s2_num[k]  <= NUM_W'(NUM_W'(s1_travel) * NUM_W'(s1_f[k])) + NUM_W'(HALF);
      s3_prod[k] <= PROD_W'(s2_num[k]) * PROD_W'(RECIP);
    end
    if (s3_valid) begin
      for (int k = 0; k < 2; k++) begin
        positions[k] <= {s3_left, {FRAC_W{1'b0}}} + POS_W'(s3_prod[k][SHIFT +: TRAV_W]);
      end
    end
  end

  assign status.shown = shown;
  assign status.busy  = s1_valid || s2_valid || s3_valid;

`include "assert_macros.svh"

  `ASSERT_CLK(a_one_tick_in_flight, $onehot0({s1_valid, s2_valid, s3_valid}),
              "more than one tick in the sweep pipeline")
  `ASSERT_NEXT(a_shown_after_pipe, !shown && !s3_valid, !shown,
               "stripe shown without a finished tick")
  `ASSERT_CLK(a_phase_in_period, {1'b0, phase} < (PHASE_W+1)'(PERIOD),
              "field phase outside its period")

endmodule

`default_nettype wire

FILE: rtl/core/sslo_blend.sv
// per-sample coverage and blend toward white
// combinational; depends on sslo_pkg
`default_nettype none

module sslo_blend #(
  parameter int SCREEN_WIDTH = 720,
  parameter int STRIPE_WIDTH = 4
) (
  input  wire logic [sslo_pkg::COL_W-1:0]  pixel_x,
  input  wire logic [sslo_pkg::ROW_W-1:0]  pixel_y,
  input  wire logic [sslo_pkg::LUMA_W-1:0] luma_in,
  input  wire sslo_pkg::pos_t              positions [2],
  input  wire logic                        shown,
  input  wire logic                        pause,
  input  wire logic [sslo_pkg::ROW_W-1:0]  box_top,
  input  wire logic [sslo_pkg::ROW_W-1:0]  box_bottom,
  output logic [sslo_pkg::LUMA_W-1:0]      luma_out
);
  import sslo_pkg::*;

  pos_t                 pos;
  logic [COL_W-1:0]     ix;
  logic [FRAC_W-1:0]    frac;
  logic [COL_W:0]       x_ext;
  logic [COL_W:0]       ix_end;
  logic [FRAC_W:0]      cov;
  logic                 active;
  logic [LUMA_W-1:0]    diff;
  logic [LUMA_W+FRAC_W:0] prod;

  always_comb begin
    pos    = positions[pixel_y[0]];
    ix     = pos[POS_W-1:FRAC_W];
    frac   = pos[FRAC_W-1:0];
    x_ext  = {1'b0, pixel_x};
    ix_end = {1'b0, ix} + (COL_W+1)'(STRIPE_WIDTH);

    // partial at the left edge, full inside, partial at the right edge
    if (pixel_x == ix) begin
      cov = FULL_COVER - {1'b0, frac};
    end else if (x_ext > {1'b0, ix} && x_ext < ix_end) begin
      cov = FULL_COVER;
    end else if (x_ext == ix_end) begin
      cov = {1'b0, frac};
    end else begin
      cov = '0;
    end

    active = shown && !pause && pixel_y >= box_top && pixel_y < box_bottom
             && x_ext < (COL_W+1)'(SCREEN_WIDTH);

    diff = WHITE_LEVEL - luma_in;
    prod = (LUMA_W+FRAC_W+1)'(diff) * (LUMA_W+FRAC_W+1)'(cov);

    if (!active || cov == '0 || luma_in >= WHITE_LEVEL) begin
      luma_out = luma_in;
    end else begin
      luma_out = luma_in + prod[FRAC_W +: LUMA_W];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sweeping_stripe_luma_overlay.sv
// sweeping stripe luma overlay, top level: config registers, sample path, result skid
// depends on sslo_pkg, the channel interfaces, sslo_sweep and sslo_blend
//
//  port  | role   | carries
//  ------+--------+------------------------------------------
//  pix   | sink   | cmd, pixel_x, pixel_y, luma_in
//  res   | source | luma_out, one per luma sample
//  cfg   | sink   | index, data (box, enable, pause)
//
// a luma sample is blended and registered as a result; one per clock
// while pix.ready is high; a running picture tick holds pix.ready low while the
// sweep pipeline (fold, multiply, reciprocal scale) finishes; an idle tick leaves it high
// results sit in an output register backed by a one-entry skid buffer
// rst is synchronous; cfg.ready is always high
`default_nettype none

module sweeping_stripe_luma_overlay #(
  parameter int SCREEN_WIDTH = 720,
  parameter int STRIPE_WIDTH = 4,
  parameter int SWEEP_LENGTH = 50
) (
  input wire logic   clk,
  input wire logic   rst,
  sslo_pix_if.sink   pix,
  sslo_res_if.source res,
  sslo_cfg_if.sink   cfg
);
  import sslo_pkg::*;

  logic [COL_W-1:0] box_left;
  logic [COL_W-1:0] box_right;
  logic [ROW_W-1:0] box_top;
  logic [ROW_W-1:0] box_bottom;
  logic             enable;
  logic             pause;

  pos_t             positions [2];
  sweep_status_t    sweep_stat;

  logic              pix_fire;
  logic              tick;
  logic              sample;
  logic [LUMA_W-1:0] blended;

  logic              out_valid;
  logic [LUMA_W-1:0] out_luma;
  logic              skid_valid;
  logic [LUMA_W-1:0] skid_luma;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left   <= '0;
      box_right  <= '0;
      box_top    <= '0;
      box_bottom <= '0;
      enable     <= 1'b0;
      pause      <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_BOX_LEFT:   box_left   <= cfg.data;
        REG_BOX_RIGHT:  box_right  <= cfg.data;
        REG_BOX_TOP:    box_top    <= cfg.data;
        REG_BOX_BOTTOM: box_bottom <= cfg.data;
        REG_ENABLE:     enable     <= cfg.data[0];
        REG_PAUSE:      pause      <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign pix.ready = !skid_valid && !sweep_stat.busy;
  assign pix_fire  = pix.valid && pix.ready;
  assign tick      = pix_fire && (cmd_t'(pix.cmd) == CMD_TICK);
  assign sample    = pix_fire && (cmd_t'(pix.cmd) == CMD_SAMPLE);

  sslo_sweep #(
    .STRIPE_WIDTH (STRIPE_WIDTH),
    .SWEEP_LENGTH (SWEEP_LENGTH)
  ) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .enable    (enable),
    .pause     (pause),
    .box_left  (box_left),
    .box_right (box_right),
    .positions (positions),
    .status    (sweep_stat)
  );

  sslo_blend #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .STRIPE_WIDTH (STRIPE_WIDTH)
  ) u_blend (
    .pixel_x    (pix.pixel_x),
    .pixel_y    (pix.pixel_y),
    .luma_in    (pix.luma_in),
    .positions  (positions),
    .shown      (sweep_stat.shown),
    .pause      (pause),
    .box_top    (box_top),
    .box_bottom (box_bottom),
    .luma_out   (blended)
  );

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= sample;
      end
    end else if (sample) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || res.ready) begin
      out_luma <= skid_valid ? skid_luma : blended;
    end else if (sample) begin
      skid_luma <= blended;
    end
  end

  assign res.valid    = out_valid;
  assign res.luma_out = out_luma;

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_skid_behind_out, skid_valid, out_valid,
                "skid entry held with an empty output register")
  `ASSERT_NEXT(a_sample_gives_result, sample, out_valid,
               "accepted sample left no result")
  `ASSERT_IMPLY(a_no_request_while_sweeping, sweep_stat.busy, !pix.ready,
                "request taken while the sweep pipeline runs")

endmodule

`default_nettype wire

FILE: tb/sweeping_stripe_luma_overlay_tb.sv
// self-checking bench for the sweeping stripe luma overlay: directed and random
// tick/sample traffic with a per-tick sweep predictor and per-result compare
// depends on sslo_pkg, the sslo channel interfaces and sweeping_stripe_luma_overlay
`default_nettype none

module sweeping_stripe_luma_overlay_tb;
  import sslo_pkg::*;

  localparam int SCREEN_COLS = 720;
  localparam int STRIPE_W = 4;
  localparam int SWEEP_LEN = 50;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 60;

  typedef struct {
    cmd_t              cmd;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [LUMA_W-1:0] luma;
  } pix_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  sslo_pix_if pix ();
  sslo_res_if res ();
  sslo_cfg_if cfg ();

  sweeping_stripe_luma_overlay #(
    .SCREEN_WIDTH(SCREEN_COLS),
    .STRIPE_WIDTH(STRIPE_W),
    .SWEEP_LENGTH(SWEEP_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .pix(pix),
    .res(res),
    .cfg(cfg)
  );

  // shadow of the block's registers and sweep state
  logic [REG_DATA_W-1:0] box_left = '0;
  logic [REG_DATA_W-1:0] box_right = '0;
  logic [REG_DATA_W-1:0] box_top = '0;
  logic [REG_DATA_W-1:0] box_bottom = '0;
  logic                  cfg_enable = 1'b0;
  logic                  cfg_pause = 1'b0;
  logic [PHASE_W-1:0]    field_phase = '0;
  logic                  stripe_shown = 1'b0;
  pos_t                  stripe_pos [2];

  pix_req_t          pix_requests [$];
  logic [LUMA_W-1:0] luma_expected [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int ticks_sent = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int results_lit = 0;
  int setups_applied = 0;
  int cycle_count = 0;

  // per field: box_left*16 plus rounded travel*f/(SWEEP_LEN-1) on a triangle phase
  function automatic void advance_sweep();
    int travel;
    int ph;
    int f;
    int p;
    int fld;
    if (!cfg_enable || cfg_pause) begin
      stripe_shown = 1'b0;
      field_phase = '0;
      return;
    end
    travel = (int'(box_right) - STRIPE_W - int'(box_left)) * 16;
    if (travel < 0) travel = 0;
    for (fld = 0; fld < 2; fld++) begin
      ph = (int'(field_phase) + fld) % (2 * SWEEP_LEN);
      f = (ph < SWEEP_LEN) ? ph : (2 * SWEEP_LEN - 1) - ph;
      p = int'(box_left) * 16 + (travel * f + (SWEEP_LEN - 1) / 2) / (SWEEP_LEN - 1);
      stripe_pos[fld] = p[POS_W-1:0];
    end
    stripe_shown = 1'b1;
    field_phase = PHASE_W'((int'(field_phase) + 2) % (2 * SWEEP_LEN));
  endfunction

  function automatic logic [LUMA_W-1:0] blend_sample(input logic [COL_W-1:0] x,
                                                     input logic [ROW_W-1:0] y,
                                                     input logic [LUMA_W-1:0] luma);
    int ix;
    int frac;
    int cov;
    int lit;
    pos_t p;
    logic [LUMA_W-1:0] out;
    if (!stripe_shown || cfg_pause || y < box_top || y >= box_bottom) return luma;
    if (int'(x) >= SCREEN_COLS) return luma;
    p = stripe_pos[y[0]];
    ix = int'(p >> FRAC_W);
    frac = int'(p[FRAC_W-1:0]);
    if (int'(x) == ix) cov = int'(FULL_COVER) - frac;
    else if (int'(x) > ix && int'(x) < ix + STRIPE_W) cov = int'(FULL_COVER);
    else if (int'(x) == ix + STRIPE_W) cov = frac;
    else cov = 0;
    if (cov == 0 || luma >= WHITE_LEVEL) return luma;
    lit = int'(luma) + (int'(WHITE_LEVEL) - int'(luma)) * cov / int'(FULL_COVER);
    out = lit[LUMA_W-1:0];
    return out;
  endfunction

  always @(posedge clk) begin : drive_pix
    pix_req_t nxt;
    logic [LUMA_W-1:0] lit_val;
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        if (pix.cmd == CMD_TICK) begin
          advance_sweep();
          ticks_sent++;
        end else begin
          lit_val = blend_sample(pix.pixel_x, pix.pixel_y, pix.luma_in);
          luma_expected.push_back(lit_val);
          // count samples the stripe actually changes
          if (lit_val != pix.luma_in) results_lit++;
          samples_sent++;
        end
      end
      if (!pix.valid || pix.ready) begin
        if (pix_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pix_requests.pop_front();
          pix.valid <= 1'b1;
          pix.cmd <= nxt.cmd;
          pix.pixel_x <= nxt.x;
          pix.pixel_y <= nxt.y;
          pix.luma_in <= nxt.luma;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_res
    logic [LUMA_W-1:0] want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (luma_expected.size() == 0) begin
          $error("luma_out: expected none, actual %0d", res.luma_out);
          mismatches++;
        end else begin
          want = luma_expected.pop_front();
          results_checked++;
          if (res.luma_out !== want) begin
            $error("luma_out: expected %0d, actual %0d", want, res.luma_out);
            mismatches++;
          end
        end
      end
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input int val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val[REG_DATA_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_BOX_LEFT:   box_left = val[REG_DATA_W-1:0];
      REG_BOX_RIGHT:  box_right = val[REG_DATA_W-1:0];
      REG_BOX_TOP:    box_top = val[REG_DATA_W-1:0];
      REG_BOX_BOTTOM: box_bottom = val[REG_DATA_W-1:0];
      REG_ENABLE:     cfg_enable = val[0];
      REG_PAUSE:      cfg_pause = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input int l, input int r, input int t, input int b,
                             input int en, input int pa);
    write_reg(REG_BOX_LEFT, l);
    write_reg(REG_BOX_RIGHT, r);
    write_reg(REG_BOX_TOP, t);
    write_reg(REG_BOX_BOTTOM, b);
    write_reg(REG_ENABLE, en);
    write_reg(REG_PAUSE, pa);
    setups_applied++;
  endtask

  task automatic queue_tick();
    pix_req_t r;
    r.cmd = CMD_TICK;
    r.x = COL_W'($urandom);
    r.y = ROW_W'($urandom);
    r.luma = LUMA_W'($urandom);
    pix_requests.push_back(r);
  endtask

  task automatic queue_sample(input int x, input int y, input int luma);
    pix_req_t r;
    r.cmd = CMD_SAMPLE;
    r.x = x[COL_W-1:0];
    r.y = y[ROW_W-1:0];
    r.luma = luma[LUMA_W-1:0];
    pix_requests.push_back(r);
  endtask

  // everything sent and answered, then room for a tick still in the sweep pipeline
  task automatic settle();
    while (pix_requests.size() != 0 || pix.valid || luma_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one tick per field followed by a short run of samples, mostly aimed at the box
  task automatic random_fields(input int n_items);
    int added;
    int run;
    int span;
    int x;
    int y;
    int luma;
    added = 0;
    while (added < n_items) begin
      queue_tick();
      added++;
      run = $urandom_range(6);
      repeat (run) begin
        if ($urandom_range(9) == 0) begin
          x = $urandom_range(1023);
          y = $urandom_range(1023);
        end else begin
          span = (box_right > box_left) ? int'(box_right) - int'(box_left) : 8;
          x = int'(box_left) + int'($urandom_range(span + 6)) - 3;
          if (box_bottom > box_top)
            y = int'(box_top) + int'($urandom_range(int'(box_bottom) - int'(box_top) - 1));
          else
            y = $urandom_range(1023);
        end
        luma = ($urandom_range(4) == 0) ? $urandom_range(255, 225) : $urandom_range(255);
        queue_sample(x, y, luma);
        added++;
      end
    end
  endtask

  task automatic set_idling(input int profile);
    case (profile % 4)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 83; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 83; end
      default: begin send_idle_pct = 37; stall_pct = 37; end
    endcase
  endtask

  initial begin : stimulus
    int ix0;
    int ix1;
    int p;
    int setups [9][6];
    pix.valid = 1'b0;
    pix.cmd = CMD_TICK;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    pix.luma_in = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_BOX_LEFT;
    cfg.data = '0;
    stripe_pos[0] = '0;
    stripe_pos[1] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: nothing shown, tick while disabled
    queue_sample(0, 0, 0);
    queue_tick();
    settle();

    apply_setup(100, 140, 4, 12, 1, 0);
    queue_tick();
    settle();
    ix0 = int'(stripe_pos[0] >> FRAC_W);
    ix1 = int'(stripe_pos[1] >> FRAC_W);
    queue_sample(ix0, 4, 0);
    // odd row uses the second field's position, partial at both edges
    queue_sample(ix1, 5, 0);
    queue_sample(ix1 + 2, 5, 100);
    queue_sample(ix1 + STRIPE_W, 5, 200);
    queue_sample(ix1 - 1, 5, 10);
    queue_sample(ix1 + STRIPE_W + 1, 5, 10);
    queue_sample(ix1 + 1, 7, 235);
    queue_sample(ix1 + 1, 7, 255);
    queue_sample(ix0, 3, 50);
    queue_sample(ix0, 12, 50);
    queue_sample(1023, 4, 0);
    settle();

    // pause hides a shown stripe at once, the next tick clears the phase
    write_reg(REG_PAUSE, 1);
    queue_sample(ix0, 4, 0);
    queue_tick();
    settle();
    write_reg(REG_PAUSE, 0);

    // box too narrow for any travel
    apply_setup(700, 703, 4, 12, 1, 0);
    queue_tick();
    queue_sample(700, 5, 0);
    settle();

    // stripe straddling the last screen column
    apply_setup(718, 730, 4, 12, 1, 0);
    queue_tick();
    queue_sample(720, 4, 0);
    queue_sample(719, 4, 0);
    settle();

    setups = '{
      '{100, 140, 4, 40, 1, 0},
      '{300, 312, 0, 576, 1, 0},
      '{0, 1023, 0, 1023, 1, 0},
      '{718, 730, 100, 120, 1, 0},
      '{500, 503, 20, 30, 1, 0},
      '{500, 503, 20, 30, 1, 1},
      '{1023, 0, 50, 10, 1, 0},
      '{200, 230, 0, 576, 0, 0},
      '{10, 40, 2, 8, 1, 0}
    };
    for (p = 0; p < 9; p++) begin
      apply_setup(setups[p][0], setups[p][1], setups[p][2], setups[p][3],
                  setups[p][4], setups[p][5]);
      set_idling(p);
      if (p == 2) begin
        // hold off new requests until the stalled receiver has taken every result
        random_fields(PHASE_ITEMS / 2);
        while (pix_requests.size() != 0 || pix.valid || luma_expected.size() != 0)
          @(negedge clk);
        random_fields(PHASE_ITEMS / 2);
      end else begin
        random_fields(PHASE_ITEMS);
      end
      settle();
    end

    $display("covered %0d picture ticks and %0d luma samples under %0d box settings",
             ticks_sent, samples_sent, setups_applied);
    $display("%0d results compared, %0d of them brightened by the stripe",
             results_checked, results_lit);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
